FILE: rtl/gda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg: shared types and calendar helpers for the date advance unit
// Controller op codes, datapath status, and leap year / month length tables.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int unsigned BASE_YEAR = 1900;

	// command action codes
	localparam logic ACT_SET     = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// status codes returned with every result
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	// divisibility by 25 via the modular inverse of 25 mod 2^16
	localparam logic [15:0] INV25     = 16'h5C29;
	localparam logic [15:0] DIV25_MAX = 16'd2621;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] DAY_FIRST = 5'd1;
	localparam logic [4:0] DAY_LAST  = 5'd31;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DNUM,
		ST_YWALK,
		ST_MWALK,
		ST_FINISH
	} state_t;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_CHECK,
		OP_DNUM,
		OP_YWALK,
		OP_MWALK,
		OP_FINISH
	} op_t;

	// datapath status back to the controller
	typedef struct packed {
		logic yr_stop;   // remaining days fit in the working year
		logic yr_over;   // would pass the last representable year
		logic mon_stop;  // remaining days fit in the working month
	} dp_sts_t;

	// Gregorian leap test; years up to 16 bits
	function automatic logic is_leap(input logic [15:0] y);
		logic [31:0] prod;
		logic        d4;
		logic        d16;
		logic        d25;
		prod = 32'(y) * 32'(INV25);
		d4   = (y[1:0] == 2'b00);
		d16  = (y[3:0] == 4'b0000);
		d25  = (prod[15:0] <= DIV25_MAX);
		return (d4 && !d25) || (d16 && d25);
	endfunction

	function automatic logic [8:0] year_len(input logic lp);
		return lp ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] n;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2:                    n = lp ? 5'd29 : 5'd28;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

	// days in the months before month m
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic lp);
		logic [8:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		if (lp && (m > MONTH_FEB)) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

endpackage

FILE: rtl/gda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_ctrl: sequencer for the date advance unit
// Steps the datapath through validate (set) or day number, year walk and month walk (advance), then finish.
// ----------------------------------------------------------------------------
module gda_ctrl
	import gda_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    action,
	input  dp_sts_t sts,
	output logic    busy,
	output op_t     op
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (action == ACT_ADVANCE) ? ST_DNUM : ST_CHECK;
				end
			end
			ST_CHECK: state_d = ST_FINISH;
			ST_DNUM:  state_d = ST_YWALK;
			ST_YWALK: begin
				if (sts.yr_over) begin
					state_d = ST_FINISH;
				end else if (sts.yr_stop) begin
					state_d = ST_MWALK;
				end
			end
			ST_MWALK: begin
				if (sts.mon_stop) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				op   = start ? OP_LOAD : OP_NONE;
			end
			ST_CHECK:  op = OP_CHECK;
			ST_DNUM:   op = OP_DNUM;
			ST_YWALK:  op = OP_YWALK;
			ST_MWALK:  op = OP_MWALK;
			ST_FINISH: op = OP_FINISH;
			default:   op = OP_NONE;
		endcase
	end

endmodule

FILE: rtl/gda_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_dpath: date registers and day arithmetic for the date advance unit
// Holds the stored date, the working year and day total, and result registers.
// ----------------------------------------------------------------------------
module gda_dpath
	import gda_pkg::*;
#(
	parameter int YEAR_BITS    = 12,
	parameter int ADVANCE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  op_t                     op,
	input  logic                    action,
	input  logic [3:0]              new_month,
	input  logic [4:0]              new_day,
	input  logic [YEAR_BITS-1:0]    new_year,
	input  logic [ADVANCE_BITS-1:0] advance_days,
	output dp_sts_t                 sts,
	output logic                    done,
	output logic [3:0]              cur_month,
	output logic [4:0]              cur_day,
	output logic [YEAR_BITS-1:0]    cur_year,
	output logic [8:0]              day_of_year,
	output logic [8:0]              days_left,
	output logic                    leap,
	output logic [1:0]              status
);

	localparam int TOT_BITS = ((ADVANCE_BITS > 9) ? ADVANCE_BITS : 9) + 1;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX  = {YEAR_BITS{1'b1}};
	localparam logic [YEAR_BITS-1:0] YEAR_BASE = YEAR_BITS'(BASE_YEAR);

	// stored date and flags
	logic [3:0]           month_q;
	logic [4:0]           day_q;
	logic [YEAR_BITS-1:0] year_q;
	logic                 leap_q;
	logic [1:0]           status_q;
	logic                 done_q;

	// working registers
	logic [3:0]           nm_q;
	logic [4:0]           nd_q;
	logic [YEAR_BITS-1:0] wyr_q;
	logic [TOT_BITS-1:0]  tot_q;
	logic [3:0]           wmon_q;
	logic [8:0]           doy_q;
	logic [8:0]           left_q;

	logic [YEAR_BITS-1:0] yr_sel;
	logic [YEAR_BITS-1:0] wyr_inc;
	logic [TOT_BITS-1:0]  ylen;
	logic [TOT_BITS-1:0]  mlen;
	logic                 ytake;
	logic                 mtake;
	logic                 set_ok;
	logic [8:0]           doy;

	// combinational helpers
	always_comb begin
		yr_sel  = (action == ACT_ADVANCE) ? year_q : new_year;
		wyr_inc = wyr_q + YEAR_BITS'(1);
		ylen    = TOT_BITS'(year_len(leap_q));
		mlen    = TOT_BITS'(month_len(wmon_q, leap_q));
		ytake   = (tot_q > ylen);
		mtake   = (wmon_q < MONTH_DEC) && (tot_q > mlen);
		set_ok  = (nm_q >= MONTH_JAN) && (nm_q <= MONTH_DEC) && (wyr_q >= YEAR_BASE)
		          && (nd_q != 5'd0) && (nd_q <= month_len(nm_q, leap_q));
		doy     = days_before(month_q, leap_q) + 9'(day_q);
	end

	always_comb begin
		sts.yr_stop  = !ytake;
		sts.yr_over  = ytake && (wyr_q == YEAR_MAX);
		sts.mon_stop = !mtake;
	end

	// stored date, flags and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q  <= MONTH_JAN;
			day_q    <= DAY_FIRST;
			year_q   <= YEAR_BASE;
			leap_q   <= 1'b0;
			status_q <= STAT_OK;
			done_q   <= 1'b0;
		end else begin
			done_q <= (op == OP_FINISH);
			unique case (op)
				OP_LOAD: begin
					leap_q   <= is_leap(16'(yr_sel));
					status_q <= STAT_OK;
				end
				OP_CHECK: begin
					if (set_ok) begin
						month_q <= nm_q;
						day_q   <= nd_q;
						year_q  <= wyr_q;
					end else begin
						month_q  <= MONTH_JAN;
						day_q    <= DAY_FIRST;
						year_q   <= YEAR_BASE;
						leap_q   <= is_leap(16'(BASE_YEAR));
						status_q <= STAT_INVALID;
					end
				end
				OP_YWALK: begin
					if (ytake) begin
						if (wyr_q == YEAR_MAX) begin
							month_q  <= MONTH_DEC;
							day_q    <= DAY_LAST;
							year_q   <= wyr_q;
							status_q <= STAT_OVERFLOW;
						end else begin
							leap_q <= is_leap(16'(wyr_inc));
						end
					end
				end
				OP_MWALK: begin
					if (!mtake) begin
						month_q <= wmon_q;
						day_q   <= tot_q[4:0];
						year_q  <= wyr_q;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				nm_q  <= new_month;
				nd_q  <= new_day;
				wyr_q <= yr_sel;
				tot_q <= TOT_BITS'(advance_days);
			end
			OP_DNUM: begin
				tot_q  <= tot_q + TOT_BITS'(days_before(month_q, leap_q))
				          + TOT_BITS'(day_q);
				wmon_q <= MONTH_JAN;
			end
			OP_YWALK: begin
				if (ytake && (wyr_q != YEAR_MAX)) begin
					tot_q <= tot_q - ylen;
					wyr_q <= wyr_inc;
				end
			end
			OP_MWALK: begin
				if (mtake) begin
					tot_q  <= tot_q - mlen;
					wmon_q <= wmon_q + 4'd1;
				end
			end
			OP_FINISH: begin
				doy_q  <= doy;
				left_q <= year_len(leap_q) - doy;
			end
			default: ;
		endcase
	end

	// result ports
	assign done        = done_q;
	assign cur_month   = month_q;
	assign cur_day     = day_q;
	assign cur_year    = year_q;
	assign day_of_year = doy_q;
	assign days_left   = left_q;
	assign leap        = leap_q;
	assign status      = status_q;

endmodule

FILE: rtl/gregorian_date_advance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_advance_unit: Gregorian date register with set and advance
// Sets a validated date or moves the stored date forward by a day count.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------------------------
//   command  | start / busy      | action, new_month, new_day, new_year,
//            |                   | advance_days
//   result   | done (1 cycle)    | cur_month, cur_day, cur_year, day_of_year,
//            |                   | days_left, leap, status
//
// A transaction is taken at a clock edge with start high and busy low.
// Set: the date is validated, then the finish step raises done.
// Advance: a day number step, then a year walk that moves one year per
// cycle and recomputes the leap flag for each new year, then a month walk
// over 0..11 months and the finish step.
// Reset returns the date to 1/1/1900. Results stay in the date registers
// until a later command; done lasts one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
module gregorian_date_advance_unit
	import gda_pkg::*;
#(
	parameter int YEAR_BITS    = 12,
	parameter int ADVANCE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    action,
	input  logic [3:0]              new_month,
	input  logic [4:0]              new_day,
	input  logic [YEAR_BITS-1:0]    new_year,
	input  logic [ADVANCE_BITS-1:0] advance_days,
	output logic                    done,
	output logic [3:0]              cur_month,
	output logic [4:0]              cur_day,
	output logic [YEAR_BITS-1:0]    cur_year,
	output logic [8:0]              day_of_year,
	output logic [8:0]              days_left,
	output logic                    leap,
	output logic [1:0]              status
);

	op_t     op;
	dp_sts_t sts;

	// sequencer
	gda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.busy   (busy),
		.op     (op)
	);

	// date arithmetic
	gda_dpath #(
		.YEAR_BITS    (YEAR_BITS),
		.ADVANCE_BITS (ADVANCE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.action       (action),
		.new_month    (new_month),
		.new_day      (new_day),
		.new_year     (new_year),
		.advance_days (advance_days),
		.sts          (sts),
		.done         (done),
		.cur_month    (cur_month),
		.cur_day      (cur_day),
		.cur_year     (cur_year),
		.day_of_year  (day_of_year),
		.days_left    (days_left),
		.leap         (leap),
		.status       (status)
	);

endmodule
